// ===== design/tqdt_pkg.sv =====
// Package for the task queue with delay timers.
// Holds sizes, request modes and the shared task record type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tqdt_pkg;
    localparam int READY_DEPTH = 16;
    localparam int TIMER_SLOTS = 8;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS + 1);
    localparam int CNT_W       = $clog2(READY_DEPTH + 1);
    localparam int RIDX_W      = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;

    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] MODE_DISP = 2'd3;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arg;
    } task_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  task_id;
        logic [15:0] task_arg;
        logic [15:0] delay;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic        task_valid;
        logic [7:0]  out_task_id;
        logic [15:0] out_task_arg;
    } rsp_t;

    // Token passed from one timer cell to the next during a scan.
    typedef struct packed {
        logic        active;
        logic        done;     // set request already placed
        logic        free_seen;
        logic        push;     // a tick expiry to push this cycle
        task_t       ptask;
    } tok_t;
endpackage
`default_nettype wire

// ===== design/tqdt_stream_if.sv =====
// Valid/ready channel interface for requests and results.
// Depends on tqdt_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tqdt_req_if;
    import tqdt_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tqdt_rsp_if;
    import tqdt_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/tqdt_timer_cell.sv =====
// One timer slot of the chain; acts when the scan token reaches it or when a set request is placed in it.
// Depends on tqdt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tqdt_timer_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           is_tick,
    input  wire logic           place,
    input  wire tqdt_pkg::req_t req,
    input  wire tqdt_pkg::tok_t tok_in,
    output tqdt_pkg::tok_t      tok_out,
    output logic                is_free
);
    import tqdt_pkg::*;

    logic [7:0]  id_reg,  id_next;
    logic [15:0] arg_reg, arg_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        match;

    assign is_free = (id_reg == 8'd0);
    assign match   = (req.task_id != 8'd0) && (id_reg == req.task_id)
                     && (arg_reg == req.task_arg);

    // Slot update and outgoing token.
    always_comb
    begin
        id_next  = id_reg;
        arg_next = arg_reg;
        cnt_next = cnt_reg;
        tok_out  = tok_in;
        tok_out.push = 1'b0;
        // A new delayed task is written into this slot when it is the first free one.
        if (place)
        begin
            id_next  = req.task_id;
            arg_next = req.task_arg;
            cnt_next = req.delay - 16'd1;
        end
        if (tok_in.active)
        begin
            if (is_tick)
            begin
                if (!is_free)
                begin
                    if (cnt_reg != 16'd0)
                    begin
                        cnt_next = cnt_reg - 16'd1;
                    end
                    else
                    begin
                        tok_out.push  = 1'b1;
                        tok_out.ptask = '{id: id_reg, arg: arg_reg};
                        id_next       = 8'd0;
                    end
                end
            end
            else if (!tok_in.done && match)
            begin
                cnt_next     = req.delay - 16'd1;
                tok_out.done = 1'b1;
            end
            else if (is_free)
            begin
                tok_out.free_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg  <= '0;
            arg_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            id_reg  <= id_next;
            arg_reg <= arg_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/tqdt_ready_fifo.sv =====
// Ready-task FIFO as a shift queue, head at entry zero.
// Depends on tqdt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tqdt_ready_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tqdt_pkg::task_t push_task,
    input  wire logic            pop,
    output tqdt_pkg::task_t      head,
    output logic                 full,
    output logic                 empty
);
    import tqdt_pkg::*;

    task_t            q_reg [READY_DEPTH];
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(READY_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = q_reg[0];

    // Push writes at the tail; pop shifts all entries toward the head.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < READY_DEPTH; i++)
            begin
                q_reg[i] <= '0;
            end
        end
        else if (pop && !empty)
        begin
            for (int i = 0; i < READY_DEPTH - 1; i++)
            begin
                q_reg[i] <= q_reg[i + 1];
            end
            q_reg[READY_DEPTH - 1] <= '0;
            count_reg <= count_reg - CNT_W'(1);
        end
        else if (push && !full && push_task.id != 8'd0)
        begin
            q_reg[count_reg[RIDX_W-1:0]] <= push_task;
            count_reg <= count_reg + CNT_W'(1);
        end
    end
endmodule
`default_nettype wire

// ===== design/task_queue_with_delay_timers.sv =====
// Task queue with delay timers: top level; uses tqdt_pkg, the stream interfaces and the cells.
// Enqueue, dispatch and set with zero delay: result in the cycle after the request.
// Tick and set with a delay scan the timer cells one slot a cycle; set with a delay then
// passes a placement state (ST_PLACE) before its result. One request at a time; a waiting
// result holds the input off.
// Reset is asynchronous and active low and empties the queue and all timers.
`timescale 1ns / 1ps
`default_nettype none
module task_queue_with_delay_timers (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tqdt_req_if.sink    req,
    tqdt_rsp_if.source  rsp
);
    import tqdt_pkg::*;

    typedef enum logic [1:0] { ST_IDLE, ST_SCAN, ST_PLACE, ST_DONE } state_t;

    state_t            state_reg;
    req_t              req_reg;
    rsp_t              rsp_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              done_reg, free_reg;
    task_t             push_task_reg;
    logic              push_reg;

    tok_t        tok_last;
    tok_t        tok_o [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] free_v;
    logic        place_en;
    logic [SLOT_W-1:0] first_free;
    rsp_t        rsp_idle;

    logic  f_push, f_pop, f_full, f_empty;
    task_t f_push_task, f_head;
    logic  is_tick, scan_active;

    assign is_tick     = (req_reg.mode == MODE_TICK);
    assign scan_active = (state_reg == ST_SCAN);

    // A set request that matched no slot goes to the first free slot.
    assign place_en = (state_reg == ST_PLACE) && !done_reg && free_reg
                      && (req_reg.task_id != 8'd0);

    // Token enters the cell chosen by the scan counter only.
    for (genvar g = 0; g < TIMER_SLOTS; g++)
    begin : g_cell
        tok_t tin;
        always_comb
        begin
            tin        = '0;
            tin.active = scan_active && (slot_reg == SLOT_W'(g));
            tin.done   = done_reg;
            tin.free_seen = free_reg;
        end
        tqdt_timer_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .is_tick (is_tick),
            .place   (place_en && (first_free == SLOT_W'(g))),
            .req     (req_reg),
            .tok_in  (tin),
            .tok_out (tok_o[g]),
            .is_free (free_v[g])
        );
    end

    // Token leaving the cell that is scanned this cycle.
    always_comb
    begin
        tok_last = '0;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            if (scan_active && slot_reg == SLOT_W'(i))
            begin
                tok_last = tok_o[i];
            end
        end
    end

    assign f_push      = push_reg || (state_reg == ST_IDLE && req.valid && req.ready
                         && (req.data.mode == MODE_ENQ || (req.data.mode == MODE_SET
                         && req.data.delay == 16'd0)));
    assign f_push_task = push_reg ? push_task_reg
                         : '{id: req.data.task_id, arg: req.data.task_arg};
    assign f_pop       = (state_reg == ST_IDLE && req.valid && req.ready
                         && req.data.mode == MODE_DISP);

    tqdt_ready_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_task (f_push_task),
        .pop       (f_pop),
        .head      (f_head),
        .full      (f_full),
        .empty     (f_empty)
    );

    assign req.ready = (state_reg == ST_IDLE) && !rsp.valid && !push_reg;
    assign rsp.valid = (state_reg == ST_DONE);
    assign rsp.data  = rsp_reg;

    // Lowest-numbered free slot; slot ids do not change during a set scan.
    always_comb
    begin
        first_free = SLOT_W'(TIMER_SLOTS);
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (free_v[i])
            begin
                first_free = SLOT_W'(i);
            end
        end
    end

    // Result of a request that finishes without a scan.
    always_comb
    begin
        rsp_idle = '{ok: 1'b1, task_valid: 1'b0, out_task_id: 8'd0, out_task_arg: 16'd0};
        case (req.data.mode)
            MODE_ENQ:
            begin
                rsp_idle.ok = !f_full;
            end
            MODE_SET:
            begin
                if (req.data.delay == 16'd0)
                begin
                    rsp_idle.ok = !f_full;
                end
            end
            MODE_DISP:
            begin
                rsp_idle.ok           = !f_empty;
                rsp_idle.task_valid   = !f_empty;
                rsp_idle.out_task_id  = f_empty ? 8'd0 : f_head.id;
                rsp_idle.out_task_arg = f_empty ? 16'd0 : f_head.arg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            done_reg  <= 1'b0;
            free_reg  <= 1'b0;
            push_reg  <= 1'b0;
            push_task_reg <= '0;
            req_reg   <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            push_reg <= scan_active && tok_last.push;
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        req_reg  <= req.data;
                        slot_reg <= '0;
                        done_reg <= 1'b0;
                        free_reg <= 1'b0;
                        rsp_reg  <= rsp_idle;
                        case (req.data.mode)
                            MODE_SET:
                            begin
                                state_reg <= (req.data.delay == 16'd0) ? ST_DONE : ST_SCAN;
                            end
                            MODE_TICK:
                            begin
                                state_reg <= ST_SCAN;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    done_reg <= tok_last.done;
                    free_reg <= tok_last.free_seen;
                    push_task_reg <= tok_last.ptask;
                    if (slot_reg == SLOT_W'(TIMER_SLOTS - 1))
                    begin
                        state_reg <= is_tick ? ST_DONE : ST_PLACE;
                    end
                    slot_reg <= slot_reg + SLOT_W'(1);
                end
                ST_PLACE:
                begin
                    rsp_reg.ok <= done_reg || free_reg;
                    state_reg  <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/task_queue_with_delay_timers_tb.sv =====
// Testbench for the task queue with delay timers.
// Drives requests through tqdt_req_if and checks every result against a behavioral predictor.
// Depends on tqdt_pkg, tqdt_stream_if and the task_queue_with_delay_timers RTL.
`timescale 1ns / 1ps
module task_queue_with_delay_timers_tb;
    import tqdt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1700;

    logic clk;
    logic rst_n;
    int   cycles;
    int   errors;
    bit   stim_done;
    bit   hold_off;

    tqdt_req_if req ();
    tqdt_rsp_if rsp ();

    task_queue_with_delay_timers dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Predictor state: ready queue and timer table.
    task_t       queue_model[$];
    logic [7:0]  slot_id[TIMER_SLOTS];
    logic [15:0] slot_arg[TIMER_SLOTS];
    logic [15:0] slot_cnt[TIMER_SLOTS];
    rsp_t        pending_rsp[$];

    // Directed stimulus: request plus an optional typed-in expected result.
    typedef struct {
        req_t r;
        bit   fixed;
        rsp_t e;
    } vec_t;
    vec_t dir_vecs[$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("task_queue_with_delay_timers: mismatch");
            $finish;
        end
    end

    function automatic bit queue_push(input logic [7:0] id, input logic [15:0] arg);
        task_t t;
        if (queue_model.size() >= READY_DEPTH)
            return 1'b0;
        t.id  = id;
        t.arg = arg;
        if (id != 8'd0)
            queue_model.push_back(t);
        return 1'b1;
    endfunction

    // Computes the result of one request and updates the predictor.
    function automatic rsp_t dispatcher_step(input req_t r);
        rsp_t  o;
        int    pick;
        task_t t;
        o = '{ok: 1'b1, task_valid: 1'b0, out_task_id: 8'd0, out_task_arg: 16'd0};
        case (r.mode)
            MODE_ENQ:  o.ok = queue_push(r.task_id, r.task_arg);
            MODE_SET:
            begin
                if (r.delay == 16'd0)
                    o.ok = queue_push(r.task_id, r.task_arg);
                else
                begin
                    pick = -1;
                    for (int s = 0; s < TIMER_SLOTS; s++)
                    begin
                        if (r.task_id != 0 && slot_id[s] == r.task_id
                            && slot_arg[s] == r.task_arg)
                        begin
                            pick = s;
                            break;
                        end
                        if (slot_id[s] == 0 && pick < 0)
                            pick = s;
                    end
                    o.ok = (pick >= 0);
                    if (pick >= 0 && r.task_id != 0)
                    begin
                        slot_id[pick]  = r.task_id;
                        slot_arg[pick] = r.task_arg;
                        slot_cnt[pick] = r.delay - 16'd1;
                    end
                end
            end
            MODE_TICK:
            begin
                for (int s = 0; s < TIMER_SLOTS; s++)
                begin
                    if (slot_id[s] == 0)
                        continue;
                    if (slot_cnt[s] != 0)
                        slot_cnt[s]--;
                    else
                    begin
                        void'(queue_push(slot_id[s], slot_arg[s]));
                        slot_id[s] = 8'd0;
                    end
                end
            end
            default:
            begin
                if (queue_model.size() == 0)
                    o.ok = 1'b0;
                else
                begin
                    t = queue_model.pop_front();
                    o.task_valid   = 1'b1;
                    o.out_task_id  = t.id;
                    o.out_task_arg = t.arg;
                end
            end
        endcase
        return o;
    endfunction

    function automatic req_t mk(input logic [1:0] m, input logic [7:0] id,
                                input logic [15:0] arg, input logic [15:0] d);
        req_t r;
        r.mode = m; r.task_id = id; r.task_arg = arg; r.delay = d;
        return r;
    endfunction

    // Random request: mostly real tasks with small ids so timers get re-armed.
    function automatic req_t random_request();
        req_t r;
        int   k;
        k = $urandom_range(0, 99);
        r.mode     = (k < 25) ? MODE_ENQ : (k < 50) ? MODE_SET :
                     (k < 75) ? MODE_TICK : MODE_DISP;
        r.task_id  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        r.task_arg = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0:       r.delay = 16'($urandom);
            1:       r.delay = 16'd0;
            default: r.delay = 16'($urandom_range(1, 6));
        endcase
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input req_t r, input bit fixed, input rsp_t e);
        rsp_t p;
        int   gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        p = dispatcher_step(r);
        if (fixed && p !== e)
        begin
            $display("%0t table entry disagrees: expected %h actual %h", $time, e, p);
            errors++;
        end
        pending_rsp.push_back(p);
        @(negedge clk);
    endtask

    // Result checker, sampled at the rising edge.
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time, rsp.data);
                errors++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (rsp.data.ok !== e.ok)
                    $display("%0t ok: expected %b actual %b", $time, e.ok, rsp.data.ok);
                if (rsp.data.task_valid !== e.task_valid)
                    $display("%0t task_valid: expected %b actual %b", $time,
                             e.task_valid, rsp.data.task_valid);
                if (rsp.data.out_task_id !== e.out_task_id)
                    $display("%0t out_task_id: expected %h actual %h", $time,
                             e.out_task_id, rsp.data.out_task_id);
                if (rsp.data.out_task_arg !== e.out_task_arg)
                    $display("%0t out_task_arg: expected %h actual %h", $time,
                             e.out_task_arg, rsp.data.out_task_arg);
                if (rsp.data !== e)
                    errors++;
            end
        end
    end

    // Receiver stalls, with one long hold-off while requests keep coming.
    initial
    begin
        int w;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                rsp.ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            rsp.ready <= (w == 0);
            if (w != 0)
            begin
                repeat (w) @(negedge clk);
                rsp.ready <= 1'b1;
            end
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        rsp_t none_e;
        rsp_t ok1;
        rsp_t fail;
        int   waited;
        none_e = '{ok: 1'b0, task_valid: 1'b0, out_task_id: 8'd0, out_task_arg: 16'd0};
        ok1    = '{ok: 1'b1, task_valid: 1'b0, out_task_id: 8'd0, out_task_arg: 16'd0};
        fail   = none_e;
        cycles = 0;
        errors = 0;
        stim_done = 1'b0;
        hold_off  = 1'b0;
        req.valid = 1'b0;
        req.data  = '0;
        rst_n     = 1'b0;
        for (int s = 0; s < TIMER_SLOTS; s++)
        begin
            slot_id[s] = 0; slot_arg[s] = 0; slot_cnt[s] = 0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: empty dispatch, extremes, id zero, full queue and table.
        dir_vecs.push_back('{mk(MODE_DISP, 8'd0, 16'd0, 16'd0), 1, none_e});
        dir_vecs.push_back('{mk(MODE_TICK, 8'd0, 16'd0, 16'd0), 1, ok1});
        dir_vecs.push_back('{mk(MODE_ENQ, 8'd0, 16'hFFFF, 16'd0), 1, ok1});
        dir_vecs.push_back('{mk(MODE_ENQ, 8'hFF, 16'hFFFF, 16'hFFFF), 1, ok1});
        dir_vecs.push_back('{mk(MODE_DISP, 8'd0, 16'd0, 16'd0), 1,
                            '{1'b1, 1'b1, 8'hFF, 16'hFFFF}});
        dir_vecs.push_back('{mk(MODE_SET, 8'd1, 16'd0, 16'd0), 1, ok1});
        dir_vecs.push_back('{mk(MODE_SET, 8'd0, 16'd5, 16'd3), 1, ok1});
        dir_vecs.push_back('{mk(MODE_SET, 8'd2, 16'd7, 16'hFFFF), 0, none_e});
        dir_vecs.push_back('{mk(MODE_SET, 8'd2, 16'd7, 16'd1), 0, none_e});
        dir_vecs.push_back('{mk(MODE_SET, 8'd3, 16'd0, 16'd2), 0, none_e});
        for (int i = 0; i < 3; i++)
            dir_vecs.push_back('{mk(MODE_TICK, 8'd0, 16'd0, 16'd0), 0, none_e});
        for (int i = 0; i < 4; i++)
            dir_vecs.push_back('{mk(MODE_DISP, 8'd0, 16'd0, 16'd0), 0, none_e});
        for (int i = 0; i < READY_DEPTH; i++)
            dir_vecs.push_back('{mk(MODE_ENQ, 8'(i + 1), 16'(i), 16'd0), 0, none_e});
        dir_vecs.push_back('{mk(MODE_ENQ, 8'd9, 16'd9, 16'd0), 1, fail});
        dir_vecs.push_back('{mk(MODE_SET, 8'd9, 16'd9, 16'd0), 1, fail});
        dir_vecs.push_back('{mk(MODE_ENQ, 8'd0, 16'd0, 16'd0), 1, fail});
        for (int i = 0; i < TIMER_SLOTS; i++)
            dir_vecs.push_back('{mk(MODE_SET, 8'(i + 10), 16'hAAAA, 16'd1), 0, none_e});
        dir_vecs.push_back('{mk(MODE_SET, 8'd0, 16'd0, 16'd4), 1, fail});
        dir_vecs.push_back('{mk(MODE_SET, 8'd99, 16'd0, 16'd4), 1, fail});
        // Expiry with a full queue drops the tasks but frees the slots.
        dir_vecs.push_back('{mk(MODE_TICK, 8'd0, 16'd0, 16'd0), 1, ok1});
        dir_vecs.push_back('{mk(MODE_SET, 8'd10, 16'hAAAA, 16'd1), 1, ok1});

        foreach (dir_vecs[i])
            send_request(dir_vecs[i].r, dir_vecs[i].fixed, dir_vecs[i].e);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
                hold_off = 1'b1;
            send_request(random_request(), 1'b0, none_e);
        end
        req.valid <= 1'b0;

        waited = 0;
        while (pending_rsp.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("task_queue_with_delay_timers: match");
        else
            $display("task_queue_with_delay_timers: mismatch");
        $finish;
    end
endmodule
